// ----- sv/rpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_pkg: shared definitions for the rectangular/polar converter
// Constants, types and helper functions used by the CORDIC pipeline and its
// checker.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Default values of the top level's parameters.
  localparam int ITERATIONS_DEF  = 16;
  localparam int DATA_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // Number of entries in the arctangent table, and the cap on iterations.
  localparam int TABLE_LEN = 24;

  // Guard bits carried below the input LSB through the iterations.
  localparam int GUARD = 8;

  // Width of the working x and y values; covers the CORDIC growth.
  localparam int XW = 27;

  // Width of the gain compensation product.
  localparam int PW = XW + 33;

  // Width used for saturation compares, wide enough for data widths up to 32 bits.
  localparam int CW = 34;

  // Inverse CORDIC gain in Q32 and angle landmarks in Q32 turns.
  localparam logic signed [32:0] INVK_S       = 33'sd2608131496;
  localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;

  typedef logic signed [XW-1:0] xy_t;

  // Side information that travels with each item through the pipeline.
  typedef struct packed {
    logic        op;
    logic        origin;
    logic        err;
    logic [15:0] re_pass;
    logic [15:0] im_pass;
    logic [15:0] mod_pass;
    logic [15:0] ang_pass;
  } side_t;

  // Arctangent of 2^-idx in Q32 turns, rounded to nearest.
  function automatic logic [31:0] atan_q32(input int idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Clamp a value to the symmetric range [-lim, lim].
  function automatic logic signed [CW-1:0] saturate(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] lim);
    logic signed [CW-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rect_polar_converter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rect_polar_converter_unit: pipelined CORDIC rectangular/polar converter
// Converts one complex value per clock between rectangular and polar form.
// ----------------------------------------------------------------------------
// Usage:
//   An item is transferred at a rising edge where start is high and busy is
//   low. busy is high only while rst is asserted, so outside reset a new item
//   may be presented in every cycle.
//   op = 0 takes real_in/imag_in and returns modulus_out/angle_out (vectoring),
//   passing the components through. op = 1 takes modulus_in/angle_in and
//   returns real_out/imag_out (rotation), passing modulus and wrapped angle
//   through. A negative modulus_in with op = 1 sets error and zeroes the rest.
//   Each result is shown for one cycle with done high; the receiver must take
//   it then, since it cannot stall the pipeline.
// Pipeline and throughput:
//   done rises after one prepare stage, one stage per CORDIC iteration, one
//   multiply stage for the gain compensation and one rounding/output stage.
//   Throughput is one item per cycle outside reset, set by the fully unrolled
//   iteration stages.
// Reset:
//   A synchronous rst clears all valid bits, so items in flight are dropped.
// ----------------------------------------------------------------------------
module rect_polar_converter_unit #(
  parameter int ITERATIONS  = rpc_pkg::ITERATIONS_DEF,
  parameter int DATA_WIDTH  = rpc_pkg::DATA_WIDTH_DEF,
  parameter int ANGLE_WIDTH = rpc_pkg::ANGLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic signed [15:0] real_in,
  input  logic signed [15:0] imag_in,
  input  logic signed [16:0] modulus_in,
  input  logic signed [31:0] angle_in,
  output logic               done,
  output logic signed [16:0] real_out,
  output logic signed [16:0] imag_out,
  output logic [15:0]        modulus_out,
  output logic [15:0]        angle_out,
  output logic               error
);
  import rpc_pkg::*;

  localparam int NITER  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int ASHIFT = 32 - ANGLE_WIDTH;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_WIDTH) - 64'd1);
  localparam logic [32:0] AHALF = 33'((64'd1 << ASHIFT) >> 1);
  localparam logic signed [CW-1:0] SAT_LIM = CW'((64'sd1 <<< DATA_WIDTH) - 64'sd1);
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sd1 <<< (31 + GUARD));

  logic accept;

  // The pipeline never stalls; it only refuses transfers during reset.
  assign busy   = rst;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Prepare stage: wrap the angle, fold into the right half plane, add guards.
  // --------------------------------------------------------------------------
  logic [31:0]          ang_w;
  logic [31:0]          ang_q;
  logic signed [31:0]   ang_s;
  logic                 wrap_back;
  logic signed [CW-1:0] mod_sat;
  xy_t                  x_init;
  xy_t                  y_init;
  logic [31:0]          z_init;
  side_t                side_init;

  always_comb begin
    ang_w     = $unsigned(angle_in) & AMASK;
    ang_q     = ang_w << ASHIFT;
    ang_s     = $signed(ang_q);
    wrap_back = (ang_s > $signed(QUARTER_TURN)) || (ang_s < -$signed(QUARTER_TURN));
    mod_sat   = saturate(CW'(modulus_in), SAT_LIM);

    side_init.op       = op;
    side_init.origin   = (real_in == 16'sd0) && (imag_in == 16'sd0);
    side_init.err      = op && modulus_in[16];
    side_init.re_pass  = real_in;
    side_init.im_pass  = imag_in;
    side_init.mod_pass = mod_sat[15:0];
    side_init.ang_pass = ang_w[15:0];

    if (!op) begin
      // Vectoring: a vector in the left half plane is turned by half a turn.
      if (real_in[15]) begin
        x_init = -(xy_t'(real_in) <<< GUARD);
        y_init = -(xy_t'(imag_in) <<< GUARD);
        z_init = HALF_TURN;
      end else begin
        x_init = xy_t'(real_in) <<< GUARD;
        y_init = xy_t'(imag_in) <<< GUARD;
        z_init = '0;
      end
    end else begin
      // Rotation: angles in the back half start from the negated vector.
      x_init = xy_t'(modulus_in) <<< GUARD;
      y_init = '0;
      z_init = ang_q;
      if (wrap_back) begin
        x_init = -(xy_t'(modulus_in) <<< GUARD);
        z_init = {~ang_q[31], ang_q[30:0]};
      end
    end
  end

  logic  vld     [0:NITER];
  xy_t   x_st    [0:NITER];
  xy_t   y_st    [0:NITER];
  logic [31:0] z_st [0:NITER];
  side_t side_st [0:NITER];

  // Prepare stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    x_st[0]    <= x_init;
    y_st[0]    <= y_init;
    z_st[0]    <= z_init;
    side_st[0] <= side_init;
  end

  // --------------------------------------------------------------------------
  // CORDIC iterations, one register stage each.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NITER; k++) begin : g_iter
    logic        sub_x;
    xy_t         dx;
    xy_t         dy;
    logic [31:0] da;

    // Rotation steers on the residual angle, vectoring on the sign of y.
    assign sub_x = side_st[k].op ? ~z_st[k][31] : y_st[k][XW-1];
    assign dx    = y_st[k] >>> k;
    assign dy    = x_st[k] >>> k;
    assign da    = atan_q32(k);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      side_st[k+1] <= side_st[k];
      if (sub_x) begin
        x_st[k+1] <= x_st[k] - dx;
        y_st[k+1] <= y_st[k] + dy;
        z_st[k+1] <= z_st[k] - da;
      end else begin
        x_st[k+1] <= x_st[k] + dx;
        y_st[k+1] <= y_st[k] - dy;
        z_st[k+1] <= z_st[k] + da;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gain compensation multiply.
  // --------------------------------------------------------------------------
  logic                 vld_p;
  side_t                side_p;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic [31:0]          z_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else begin
      vld_p <= vld[NITER];
    end
    side_p <= side_st[NITER];
    px     <= PW'(x_st[NITER]) * PW'(INVK_S);
    py     <= PW'(y_st[NITER]) * PW'(INVK_S);
    z_p    <= z_st[NITER];
  end

  // --------------------------------------------------------------------------
  // Rounding, saturation, angle quantization and result selection.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] rx_sum;
  logic signed [PW-1:0] ry_sum;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [32:0]          a_sum;
  logic [31:0]          a_q;
  logic signed [16:0]   real_out_next;
  logic signed [16:0]   imag_out_next;
  logic [15:0]          modulus_out_next;
  logic [15:0]          angle_out_next;
  logic                 error_next;

  always_comb begin
    rx_sum = px + ROUND_HALF;
    ry_sum = py + ROUND_HALF;
    cx     = saturate(CW'($signed(rx_sum[PW-1:32+GUARD])), SAT_LIM);
    cy     = saturate(CW'($signed(ry_sum[PW-1:32+GUARD])), SAT_LIM);
    // Round half up to the output angle width; a full turn wraps to zero.
    a_sum  = {1'b0, z_p} + AHALF;
    a_q    = 32'(a_sum >> ASHIFT) & AMASK;

    if (side_p.err) begin
      real_out_next    = '0;
      imag_out_next    = '0;
      modulus_out_next = '0;
      angle_out_next   = '0;
      error_next       = 1'b1;
    end else if (!side_p.op) begin
      real_out_next    = {side_p.re_pass[15], side_p.re_pass};
      imag_out_next    = {side_p.im_pass[15], side_p.im_pass};
      modulus_out_next = side_p.origin ? 16'd0 : cx[15:0];
      angle_out_next   = side_p.origin ? 16'd0 : a_q[15:0];
      error_next       = 1'b0;
    end else begin
      real_out_next    = cx[16:0];
      imag_out_next    = cy[16:0];
      modulus_out_next = side_p.mod_pass;
      angle_out_next   = side_p.ang_pass;
      error_next       = 1'b0;
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_p;
    end
    real_out    <= real_out_next;
    imag_out    <= imag_out_next;
    modulus_out <= modulus_out_next;
    angle_out   <= angle_out_next;
    error       <= error_next;
  end

endmodule
`default_nettype wire

// ----- sv/rpc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_checker: port-level assertions for the rectangular/polar converter
// Checks result timing and the special cases seen at the top level's ports.
// ----------------------------------------------------------------------------
module rpc_checker #(
  parameter int ITERATIONS = rpc_pkg::ITERATIONS_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               op,
  input wire logic signed [15:0] real_in,
  input wire logic signed [15:0] imag_in,
  input wire logic signed [16:0] modulus_in,
  input wire logic               done,
  input wire logic signed [16:0] real_out,
  input wire logic signed [16:0] imag_out,
  input wire logic [15:0]        modulus_out,
  input wire logic [15:0]        angle_out,
  input wire logic               error
);
  import rpc_pkg::*;

  localparam int NITER = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int LAT   = NITER + 3;

  logic xfer;
  logic origin_xfer;
  logic neg_mod_xfer;

  assign xfer         = start && !busy;
  assign origin_xfer  = xfer && !op && (real_in == 16'sd0) && (imag_in == 16'sd0);
  assign neg_mod_xfer = xfer && op && modulus_in[16];

  // Every transfer produces exactly one result after the pipeline latency.
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    xfer |-> ##LAT done)
    else $error("transfer without a result after the pipeline latency");

  // No result appears without a transfer at the matching earlier edge.
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(xfer, LAT))
    else $error("result without a matching transfer");

  // An error result comes only from a polar item with negative modulus.
  a_error_source : assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> $past(neg_mod_xfer, LAT))
    else $error("error result without a negative modulus transfer");

  // An error result carries all-zero fields.
  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (real_out == 17'sd0) && (imag_out == 17'sd0) &&
                        (modulus_out == 16'd0) && (angle_out == 16'd0))
    else $error("error result with nonzero fields");

  // The origin converts to zero modulus and zero angle.
  a_origin_zero : assert property (@(posedge clk) disable iff (rst)
    (done && $past(origin_xfer, LAT)) |-> (modulus_out == 16'd0) && (angle_out == 16'd0))
    else $error("origin did not convert to zero modulus and angle");

endmodule

bind rect_polar_converter_unit rpc_checker #(.ITERATIONS(ITERATIONS)) u_rpc_checker (.*);
`default_nettype wire

// ----- bench/rect_polar_converter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_polar_converter_unit_tb: self-checking bench for the CORDIC converter
// Drives rectangular and polar items through the pipelined converter, computes
// every expected result with a behavioral CORDIC model in the bench, and checks
// each strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rect_polar_converter_unit_tb;

  localparam int     N_ITER     = 16;
  localparam int     D_W        = 16;
  localparam int     A_W        = 16;
  localparam int     ITER_USED  = (N_ITER < 24) ? N_ITER : 24;
  localparam int     LATENCY    = N_ITER + 2;
  localparam int     N_RANDOM   = 800;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint INV_GAIN   = 64'sd2608131496;
  localparam longint HALF_TURN  = 64'sd2147483648;
  localparam longint QTR_TURN   = 64'sd1073741824;
  localparam longint DATA_LIM   = (64'sd1 <<< D_W) - 1;
  localparam logic   OP_TO_POLAR = 1'b0;
  localparam logic   OP_TO_RECT  = 1'b1;

  // One converter result as it appears on the output ports.
  typedef struct packed {
    logic signed [16:0] re;
    logic signed [16:0] im;
    logic [15:0]        modulus;
    logic [15:0]        angle;
    logic               err;
  } conv_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               op = 1'b0;
  logic signed [15:0] real_in = '0;
  logic signed [15:0] imag_in = '0;
  logic signed [16:0] modulus_in = '0;
  logic signed [31:0] angle_in = '0;
  logic               busy;
  logic               done;
  logic signed [16:0] real_out;
  logic signed [16:0] imag_out;
  logic [15:0]        modulus_out;
  logic [15:0]        angle_out;
  logic               error;

  conv_result_t pending_results[$];
  int           mismatch_count = 0;
  int           checked_count = 0;
  int           cycle_count = 0;
  int           to_polar_count = 0;
  int           to_rect_count = 0;
  int           neg_modulus_count = 0;
  bit           burst_mode = 1'b0;

  rect_polar_converter_unit #(
    .ITERATIONS (N_ITER),
    .DATA_WIDTH (D_W),
    .ANGLE_WIDTH(A_W)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .real_in    (real_in),
    .imag_in    (imag_in),
    .modulus_in (modulus_in),
    .angle_in   (angle_in),
    .done       (done),
    .real_out   (real_out),
    .imag_out   (imag_out),
    .modulus_out(modulus_out),
    .angle_out  (angle_out),
    .error      (error)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Arctangent of 2^-idx as a fraction of a full turn, scaled by 2^32.
  function automatic longint atan_turns(int idx);
    longint a;
    case (idx)
      0:       a = 536870912;
      1:       a = 316933406;
      2:       a = 167458907;
      3:       a = 85004756;
      4:       a = 42667331;
      5:       a = 21354465;
      6:       a = 10679838;
      7:       a = 5340245;
      8:       a = 2670163;
      9:       a = 1335087;
      10:      a = 667544;
      11:      a = 333772;
      12:      a = 166886;
      13:      a = 83443;
      14:      a = 41722;
      15:      a = 20861;
      16:      a = 10430;
      17:      a = 5215;
      18:      a = 2608;
      19:      a = 1304;
      20:      a = 652;
      21:      a = 326;
      22:      a = 163;
      23:      a = 81;
      default: a = 0;
    endcase
    return a;
  endfunction

  // Clamp to the symmetric data range.
  function automatic longint clamp_data(longint v);
    if (v > DATA_LIM) return DATA_LIM;
    if (v < -DATA_LIM) return -DATA_LIM;
    return v;
  endfunction

  // Strip the CORDIC gain and the 8 guard bits, rounding half up.
  function automatic longint remove_gain(longint v);
    return (v * INV_GAIN + (64'sd1 <<< 39)) >>> 40;
  endfunction

  // Expected converter output for one transferred item.
  function automatic conv_result_t predict_conversion(logic op_v,
                                                      logic signed [15:0] re_v,
                                                      logic signed [15:0] im_v,
                                                      logic signed [16:0] mod_v,
                                                      logic signed [31:0] ang_v);
    conv_result_t r;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint m;
    longint tmp;
    r = '0;
    if (op_v == OP_TO_POLAR) begin
      // Vectoring: components pass through, modulus and angle are computed.
      r.re = {re_v[15], re_v};
      r.im = {im_v[15], im_v};
      if (re_v != 0 || im_v != 0) begin
        x = longint'(re_v) * 256;
        y = longint'(im_v) * 256;
        z = 0;
        // Left half plane: rotate by half a turn first.
        if (x < 0) begin
          x = -x;
          y = -y;
          z = HALF_TURN;
        end
        for (int i = 0; i < ITER_USED; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y < 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turns(i);
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turns(i);
          end
        end
        tmp = clamp_data(remove_gain(x));
        r.modulus = tmp[15:0];
        tmp = ((z & 64'hFFFF_FFFF) + (64'sd1 <<< (31 - A_W))) >> (32 - A_W);
        r.angle = tmp[15:0];
      end
    end else begin
      m = longint'(mod_v);
      if (m < 0) begin
        r.err = 1'b1;
      end else begin
        // Rotation: wrap the angle to a signed fraction of a turn.
        z = longint'(ang_v[15:0]) << (32 - A_W);
        if (z >= HALF_TURN) z = z - 2 * HALF_TURN;
        x = m * 256;
        y = 0;
        // Back half of the turn: negate the start vector.
        if (z > QTR_TURN || z < -QTR_TURN) begin
          x = -x;
          z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
        end
        for (int i = 0; i < ITER_USED; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turns(i);
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turns(i);
          end
        end
        tmp = clamp_data(remove_gain(x));
        r.re = tmp[16:0];
        tmp = clamp_data(remove_gain(y));
        r.im = tmp[16:0];
        tmp = clamp_data(m);
        r.modulus = tmp[15:0];
        r.angle = ang_v[15:0];
      end
    end
    return r;
  endfunction

  // Record predictions at each transfer and check every strobed result.
  always @(posedge clk) begin
    conv_result_t got;
    conv_result_t want;
    if (!rst) begin
      if (done) begin
        got = '{real_out, imag_out, modulus_out, angle_out, error};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] unexpected result: re=%0d im=%0d mod=%0d ang=%0d err=%0b",
                     $time, got.re, got.im, got.modulus, got.angle, got.err);
          end
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] mismatch: expected re=%0d im=%0d mod=%0d ang=%0d err=%0b",
                       $time, want.re, want.im, want.modulus, want.angle, want.err);
              $display("[%0t]           actual   re=%0d im=%0d mod=%0d ang=%0d err=%0b",
                       $time, got.re, got.im, got.modulus, got.angle, got.err);
            end
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_conversion(op, real_in, imag_in,
                                                     modulus_in, angle_in));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Idle cycles after a transfer: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one item, wait for its transfer, then idle for a random gap.
  task automatic send_item(logic op_v, logic signed [15:0] re_v,
                           logic signed [15:0] im_v, logic signed [16:0] mod_v,
                           logic signed [31:0] ang_v);
    int gap;
    op         <= op_v;
    real_in    <= re_v;
    imag_in    <= im_v;
    modulus_in <= mod_v;
    angle_in   <= ang_v;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op_v == OP_TO_POLAR) begin
      to_polar_count++;
    end else if (mod_v < 0) begin
      neg_modulus_count++;
    end else begin
      to_rect_count++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random component, biased toward extremes and small values.
  function automatic logic signed [15:0] rand_component();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 16'sh8000;
          1:       v = 16'sh7FFF;
          2:       v = -16'sd1;
          3:       v = 16'sd1;
          default: v = 16'sd0;
        endcase
      end
      1, 2:    v = $signed(16'($urandom_range(0, 511))) - 16'sd256;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Directed vectoring items: origin, axis extremes, corners, left half plane.
  task automatic test_rect_to_polar_corners();
    send_item(OP_TO_POLAR, 16'sd0, 16'sd0, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sh7FFF, 16'sd0, -17'sd1, $urandom);
    send_item(OP_TO_POLAR, 16'sh8000, 16'sd0, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sd0, 16'sh7FFF, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sd0, 16'sh8000, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sh8000, 16'sh8000, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sh7FFF, 16'sh7FFF, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sh8000, 16'sh7FFF, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, -16'sd1, 16'sd0, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, -16'sd5, -16'sd3, 17'($urandom), $urandom);
    send_item(OP_TO_POLAR, 16'sd1, -16'sd1, 17'($urandom), $urandom);
  endtask

  // Directed rotation items: quadrant boundaries, wrapping and full-scale modulus.
  task automatic test_polar_to_rect_quadrants();
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd65535, 32'sd0);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd65535, 32'sd16384);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd65535, 32'sd32768);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd65535, -32'sd16384);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd1000, 32'sd16385);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd65535, 32'sd49151);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd0, 32'sd12345);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd100, 32'sh8000_0000);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd100, 32'sh7FFF_FFFF);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sd65535, 32'sh1234_5678);
  endtask

  // A negative modulus must raise the error flag and clear everything else.
  task automatic test_negative_modulus();
    send_item(OP_TO_RECT, rand_component(), rand_component(), -17'sd1, 32'sd1000);
    send_item(OP_TO_RECT, rand_component(), rand_component(), 17'sh10000, -32'sd1);
  endtask

  // Random mix of both directions, alternating idle and back-to-back stretches.
  task automatic test_random_stream();
    logic               op_v;
    logic signed [16:0] mod_v;
    logic signed [31:0] ang_v;
    for (int n = 0; n < N_RANDOM; n++) begin
      burst_mode = ((n / 100) % 2) == 1;
      op_v = $urandom_range(0, 1);
      if ($urandom_range(0, 99) < 15) begin
        mod_v = -17'sd1 - 17'($urandom_range(0, 65535));
      end else if ($urandom_range(0, 9) == 0) begin
        mod_v = 17'sd65535;
      end else begin
        mod_v = 17'($urandom_range(0, 65535));
      end
      case ($urandom_range(0, 4))
        0:       ang_v = 32'($urandom_range(0, 7)) * 32'sd16384
                         + 32'($urandom_range(0, 4)) - 32'sd2;
        default: ang_v = $urandom;
      endcase
      send_item(op_v, rand_component(), rand_component(), mod_v, ang_v);
    end
    burst_mode = 1'b0;
  endtask

  // Test sequence.
  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rect_to_polar_corners();
    test_polar_to_rect_quadrants();
    test_negative_modulus();
    test_random_stream();
    start <= 1'b0;

    // Drain the pipeline, then watch for stray results.
    waited = 0;
    while (pending_results.size() != 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Covered %0d rectangular-to-polar, %0d polar-to-rectangular and %0d",
             to_polar_count, to_rect_count, neg_modulus_count);
    $display("negative-modulus transfers; %0d results checked, %0d mismatches.",
             checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
